// ===== src/fvn_pkg.sv =====
// Package for the fractal value noise unit: register indexes, hash constants
// and the sequencer state type. No dependencies.
package fvn_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVE_COUNT  = 2'd0,
    CFG_BASE_AMP      = 2'd1,
    CFG_PERSISTENCE   = 2'd2,
    CFG_OFFSET        = 2'd3
  } cfg_idx_e;

  // Integer hash constants.
  localparam int unsigned HASH_SHIFT = 13;
  localparam logic [31:0] HASH_MUL_C = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;

  // Persistence has a fixed 16-bit fraction; amplitude saturates at 32 bits.
  localparam int PERS_FRAC = 16;
  localparam int AMP_W = 32;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_AMP  = 11'b000_0000_0010,
    S_H0   = 11'b000_0000_0100,
    S_H1   = 11'b000_0000_1000,
    S_H2   = 11'b000_0001_0000,
    S_SQ   = 11'b000_0010_0000,
    S_SS   = 11'b000_0100_0000,
    S_BL   = 11'b000_1000_0000,
    S_TERM = 11'b001_0000_0000,
    S_ACC  = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_e;

endpackage

// ===== src/fractal_value_noise_1d_unit.sv =====
// Fractal 1-D value noise unit: sequencer around one shared signed multiplier.
// Depends on fvn_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / position_i) takes one Q16.16
//   position. Output channel (out_valid_o / out_ready_i / noise_sum_o) returns
//   the saturated Q16.16 octave sum. The configuration channel (cfg_valid_i,
//   cfg_ready_o, cfg_index_i, cfg_data_i) is always ready; write it only
//   while the unit is idle.
//   One item is worked on at a time. With n octaves (octave_count clamped to
//   MAX_OCTAVES), the sequencer runs n octaves and then moves the saturated
//   sum to the output register, and the unit is ready for the next item in the
//   same cycle that the result becomes valid. Every octave makes 17 passes
//   through the shared multiplier: amplitude update, three multiplies for
//   each of four lattice hashes, smoothstep (two), blend and term weighting,
//   plus one accumulate step.
//   A finished result sits in an output register; if the receiver stalls,
//   the unit holds the next finished result until that register frees up.
//   Reset returns the sequencer to idle, drops any pending result and loads
//   the register defaults (4 octaves, amplitude 1.0, persistence 0.5,
//   offset 0).
module fractal_value_noise_1d_unit #(
  parameter int MAX_OCTAVES = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [31:0]             position_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             noise_sum_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fvn_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fvn_pkg::*;

  // Derived widths.
  localparam int LAT_W   = FRAC_BITS + 2;        // lattice and smoothed values
  localparam int DIFF_W  = LAT_W + 1;            // b - a
  localparam int TRI_W   = FRAC_BITS + 3;        // 3*ONE - 2*t, and f
  localparam int BLEND_W = FRAC_BITS + 5;        // blended value
  localparam int MUL_W   = (BLEND_W > AMP_W + 1) ? BLEND_W : AMP_W + 1;
  localparam int PW      = 2 * MUL_W;            // product width
  localparam int TERM_W  = BLEND_W + AMP_W + 1 - FRAC_BITS;
  localparam int ACC_W   = TERM_W + $clog2(MAX_OCTAVES + 1);
  localparam int SH_W    = FRAC_BITS + 32;       // coordinate bits kept
  localparam int CNT_W   = $clog2(MAX_OCTAVES + 1);

  localparam logic signed [LAT_W-1:0] ONE_LAT   = LAT_W'(64'd1 << FRAC_BITS);
  localparam logic [TRI_W-1:0]        THREE_ONE = TRI_W'(64'd3 << FRAC_BITS);
  localparam logic signed [PW-1:0]    RND_ADJ   = PW'((64'd1 << FRAC_BITS) - 64'd1);

  // Configuration registers.
  logic [4:0]         oct_cfg_q;
  logic [23:0]        base_amp_q;
  logic [16:0]        pers_q;
  logic signed [31:0] offset_q;

  // Control state.
  state_e     state_q, state_d;
  logic [1:0] hsel_q, hsel_d;
  logic [CNT_W-1:0] oct_q, oct_d;
  logic       out_valid_q, out_valid_d;

  // Datapath registers.
  logic                     neg_q;
  logic [SH_W-1:0]          sh_q;
  logic [AMP_W-1:0]         amp_q;
  logic [CNT_W-1:0]         n_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [LAT_W-1:0]  lat_q [4];
  logic signed [LAT_W-1:0]  sa_q, sb_q;
  logic signed [31:0]       out_q;

  // Combinational signals.
  logic                     in_xfer, out_xfer, fin_load;
  logic signed [32:0]       diff_pos;
  logic [32:0]              mag;
  logic [CNT_W-1:0]         n_clamp;
  logic [31:0]              ipart, icur, hx, hh;
  logic [FRAC_BITS-1:0]     fpart;
  logic [TRI_W-1:0]         tri_v;
  logic signed [LAT_W-1:0]  lat_new;
  logic [30:0]              hash_v;
  logic signed [DIFF_W-1:0] sdiff;
  logic signed [PW-1:0]     bl_sum, bl_rnd, t_rnd;
  logic signed [BLEND_W-1:0] blend;
  logic signed [TERM_W-1:0] term;
  logic [AMP_W-1:0]         amp_next;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]     mul_p;
  logic [31:0]              sat_val;

  // Smoothed lattice value: (2*mid + left + right) / 4, toward zero.
  function automatic logic signed [LAT_W-1:0] smooth(
    input logic signed [LAT_W-1:0] l0,
    input logic signed [LAT_W-1:0] l1,
    input logic signed [LAT_W-1:0] l2
  );
    logic signed [LAT_W+1:0] s;
    logic signed [LAT_W+1:0] s_adj;
    s = ((LAT_W + 2)'(l1) <<< 1) + (LAT_W + 2)'(l0) + (LAT_W + 2)'(l2);
    s_adj = s + ((s < 0) ? (LAT_W + 2)'(3) : (LAT_W + 2)'(0));
    return LAT_W'(s_adj >>> 2);
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign noise_sum_o = out_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;
  assign fin_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // Input preparation: exact difference, its magnitude, clamped octave count.
  assign diff_pos = 33'(position_i) - 33'(offset_q);
  assign mag      = diff_pos[32] ? 33'(-diff_pos) : 33'(diff_pos);

  always_comb begin
    if ({27'b0, oct_cfg_q} > 32'(MAX_OCTAVES)) begin
      n_clamp = CNT_W'(MAX_OCTAVES);
    end else begin
      n_clamp = CNT_W'(oct_cfg_q);
    end
  end

  // Integer part and fraction of the scaled coordinate.
  assign ipart = sh_q[FRAC_BITS+31:FRAC_BITS];
  assign fpart = sh_q[FRAC_BITS-1:0];
  assign icur  = neg_q ? (32'd0 - ipart) : ipart;

  // Hash input for lattice point icur - 1 + hsel.
  assign hx = icur + 32'(hsel_q) - 32'd1;
  assign hh = (hx << HASH_SHIFT) ^ hx;

  // Lattice value from the finished hash product.
  assign hash_v  = 31'(prod_q[31:0] + HASH_ADD_B);
  assign lat_new = ONE_LAT - LAT_W'({1'b0, hash_v[30:30-FRAC_BITS]});

  // 3*ONE - 2*t, with t carrying the sign of the coordinate.
  assign tri_v = neg_q ? (THREE_ONE + TRI_W'({fpart, 1'b0}))
                       : (THREE_ONE - TRI_W'({fpart, 1'b0}));

  assign sdiff = DIFF_W'(sb_q) - DIFF_W'(sa_q);

  // Blend a*ONE + (b-a)*f, divided by ONE toward zero.
  assign bl_sum = (PW'(sa_q) <<< FRAC_BITS) + prod_q;
  assign bl_rnd = bl_sum + ((bl_sum < 0) ? RND_ADJ : PW'(0));
  assign blend  = BLEND_W'(bl_rnd >>> FRAC_BITS);

  // Weighted term, divided by ONE toward zero.
  assign t_rnd = prod_q + (prod_q[PW-1] ? RND_ADJ : PW'(0));
  assign term  = TERM_W'(t_rnd >>> FRAC_BITS);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_AMP: begin
        mul_a = MUL_W'(amp_q);
        mul_b = MUL_W'(pers_q);
      end
      S_H0: begin
        mul_a = MUL_W'(hh);
        mul_b = MUL_W'(hh);
      end
      S_H1: begin
        mul_a = MUL_W'(prod_q[31:0]);
        mul_b = MUL_W'(HASH_MUL_C);
      end
      S_H2: begin
        mul_a = MUL_W'(hh);
        mul_b = MUL_W'(prod_q[31:0] + HASH_ADD_A);
      end
      S_SQ: begin
        mul_a = MUL_W'(fpart);
        mul_b = MUL_W'(fpart);
      end
      S_SS: begin
        mul_a = MUL_W'(prod_q[2*FRAC_BITS-1:FRAC_BITS]);
        mul_b = MUL_W'(tri_v);
      end
      S_BL: begin
        mul_a = MUL_W'(sdiff);
        mul_b = MUL_W'(prod_q[2*FRAC_BITS+2:FRAC_BITS]);
      end
      S_TERM: begin
        mul_a = MUL_W'(blend);
        mul_b = MUL_W'(amp_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Amplitude update with saturation to 32 bits.
  assign amp_next = (|mul_p[PW-1:AMP_W+PERS_FRAC]) ? {AMP_W{1'b1}}
                                                   : mul_p[AMP_W+PERS_FRAC-1:PERS_FRAC];

  // Final sum saturated to the signed 32-bit range.
  always_comb begin
    if ((&acc_q[ACC_W-1:31]) || !(|acc_q[ACC_W-1:31])) begin
      sat_val = acc_q[31:0];
    end else if (acc_q[ACC_W-1]) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = 32'h7FFF_FFFF;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    hsel_d      = hsel_q;
    oct_d       = oct_q;
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          oct_d   = '0;
          state_d = (n_clamp == '0) ? S_FIN : S_AMP;
        end
      end
      S_AMP: begin
        hsel_d  = 2'd0;
        state_d = S_H0;
      end
      S_H0: state_d = S_H1;
      S_H1: state_d = S_H2;
      S_H2: begin
        if (hsel_q == 2'd3) begin
          state_d = S_SQ;
        end else begin
          hsel_d  = hsel_q + 2'd1;
          state_d = S_H0;
        end
      end
      S_SQ:   state_d = S_SS;
      S_SS:   state_d = S_BL;
      S_BL:   state_d = S_TERM;
      S_TERM: state_d = S_ACC;
      S_ACC: begin
        oct_d   = oct_q + CNT_W'(1);
        state_d = (oct_d == n_q) ? S_FIN : S_AMP;
      end
      S_FIN: begin
        if (fin_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hsel_q      <= '0;
      oct_q       <= '0;
      out_valid_q <= 1'b0;
      oct_cfg_q   <= 5'd4;
      base_amp_q  <= 24'd65536;
      pers_q      <= 17'd32768;
      offset_q    <= '0;
    end else begin
      state_q     <= state_d;
      hsel_q      <= hsel_d;
      oct_q       <= oct_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_OCTAVE_COUNT: oct_cfg_q  <= cfg_data_i[4:0];
          CFG_BASE_AMP:     base_amp_q <= cfg_data_i[23:0];
          CFG_PERSISTENCE:  pers_q     <= cfg_data_i[16:0];
          CFG_OFFSET:       offset_q   <= $signed(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          neg_q <= diff_pos[32];
          sh_q  <= SH_W'(mag);
          amp_q <= AMP_W'(base_amp_q);
          acc_q <= '0;
          n_q   <= n_clamp;
        end
      end
      S_AMP: begin
        amp_q <= amp_next;
        sh_q  <= {sh_q[SH_W-2:0], 1'b0};
      end
      S_H0: begin
        if (hsel_q != 2'd0) begin
          lat_q[hsel_q - 2'd1] <= lat_new;
        end
      end
      S_SQ: lat_q[3] <= lat_new;
      S_SS: begin
        sa_q <= smooth(lat_q[0], lat_q[1], lat_q[2]);
        sb_q <= smooth(lat_q[1], lat_q[2], lat_q[3]);
      end
      S_ACC: acc_q <= acc_q + ACC_W'(term);
      S_FIN: begin
        if (fin_load) begin
          out_q <= $signed(sat_val);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/fvn_checker.sv =====
// Port-level checker for the fractal value noise unit, bound to the top level.
// Depends on fractal_value_noise_1d_unit.
module fvn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] noise_sum_o
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(noise_sum_o)))
    else $error("result changed or dropped while stalled");

  // After an input transfer the unit is busy.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a position is in work");

  // A new result only appears at the end of work, never while idle.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in progress");

  // Returning to idle always leaves a result in the output register.
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("work ended without a result");

endmodule

bind fractal_value_noise_1d_unit fvn_checker u_fvn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .noise_sum_o (noise_sum_o)
);
